// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- hw/rtl/ndm_pkg.sv -----
// ----------------------------------------------------------------------------
// ndm_pkg
// Types, constants and the character decode shared by the nixie multiplexer.
// ----------------------------------------------------------------------------
package ndm_pkg;

    localparam int NUM_TUBES_DEF = 10;
    localparam int ENABLE_W      = 10;
    localparam int CODE_W        = 4;
    localparam int CHAR_W        = 8;
    localparam int TICK_W        = 16;
    localparam int PT_W          = TICK_W + 1;
    localparam int CFG_IDX_W     = 1;
    localparam int NUM_GROUPS    = 3;
    localparam int OUT_DATA_W    = 32;
    localparam int OUT_FIELD_W   = NUM_GROUPS * CODE_W + NUM_GROUPS + ENABLE_W;

    localparam logic [CFG_IDX_W-1:0] REG_ON_TICKS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_TICKS = 1'd1;

    localparam logic [TICK_W-1:0] ON_TICKS_RST  = 16'd800;
    localparam logic [TICK_W-1:0] OFF_TICKS_RST = 16'd200;

    localparam logic [CHAR_W-1:0] CHAR_CLEAR = 8'h24;  // '$'
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;  // '.'
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;  // ' '

    localparam logic [CODE_W-1:0] BLANK_CODE = 4'd15;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PARSE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_in;
        logic do_char;
        logic parse_init;
        logic parse_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic phase_start;
        logic parse_last;
        logic out_free;
    } sts_t;

    function automatic logic [CODE_W-1:0] char_code(input logic [CHAR_W-1:0] c);
        logic [CODE_W-1:0] code;
        case (c)
            "0", "u", "W": code = 4'd0;
            "1", "n", "A": code = 4'd1;
            "2", "%", "O": code = 4'd2;
            "3", "p":      code = 4'd3;
            "4", "k", "S": code = 4'd4;
            "5", "M", "V": code = 4'd5;
            "6", "m", "H": code = 4'd6;
            "7", "+", "h": code = 4'd7;
            "8", "-":      code = 4'd8;
            "9", "P", "F": code = 4'd9;
            default:       code = BLANK_CODE;
        endcase
        return code;
    endfunction

endpackage

// ----- hw/rtl/ndm_ctrl.sv -----
// ----------------------------------------------------------------------------
// ndm_ctrl
// Sequencer: takes one item, runs the store walk when a phase starts, and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module ndm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  ndm_pkg::sts_t sts,
    output ndm_pkg::cmd_t cmd
);
    import ndm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.is_tick && sts.phase_start)
                begin
                    state_next = ST_PARSE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_PARSE:
            begin
                if (sts.parse_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready       = 1'b0;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_EXEC:
            begin
                cmd.do_char    = !sts.is_tick;
                cmd.parse_init = sts.is_tick && sts.phase_start;
            end
            ST_PARSE:
            begin
                cmd.parse_step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = sts.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/ndm_datapath.sv -----
// ----------------------------------------------------------------------------
// ndm_datapath
// Text store, store walk, scan timing, group drive registers and output
// register of the nixie multiplexer.
// ----------------------------------------------------------------------------
module ndm_datapath #(
    parameter int NUM_TUBES = ndm_pkg::NUM_TUBES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [ndm_pkg::CHAR_W-1:0]      s_tdata,
    input  logic                            s_tuser,
    input  logic                            cfg_valid,
    input  logic [ndm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ndm_pkg::TICK_W-1:0]      cfg_data,
    input  ndm_pkg::cmd_t                   cmd,
    output ndm_pkg::sts_t                   sts,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ndm_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import ndm_pkg::*;

    localparam int STORE_LEN = 2 * NUM_TUBES + 1;
    localparam int IDX_W     = $clog2(STORE_LEN);
    localparam int PTR_W     = $clog2(2 * NUM_TUBES + 2);
    localparam int TUBE_W    = $clog2(NUM_TUBES);
    localparam int PAD_W     = OUT_DATA_W - OUT_FIELD_W;

    // configuration
    logic [TICK_W-1:0] on_reg;
    logic [TICK_W-1:0] off_reg;

    // captured item
    logic              func_reg;
    logic [CHAR_W-1:0] char_reg;

    // text store
    logic [STORE_LEN-1:0][CHAR_W-1:0] store_reg;
    logic [STORE_LEN-1:0][CHAR_W-1:0] store_next;
    logic [PTR_W-1:0]                 widx_reg;
    logic [PTR_W-1:0]                 widx_next;

    // store walk
    logic [PTR_W-1:0]  pos_reg;
    logic [PTR_W-1:0]  pos_next;
    logic [TUBE_W-1:0] tube_reg;
    logic [TUBE_W-1:0] tube_next;
    logic              dotp_reg;
    logic              dotp_next;
    logic [CHAR_W-1:0] rd_byte;
    logic [CODE_W-1:0] rd_code;
    logic              emit;
    logic [1:0]        grp_sel;

    // scan and drive state
    logic [1:0]                        phase_reg;
    logic [1:0]                        phase_next;
    logic [PT_W-1:0]                   pt_reg;
    logic [PT_W-1:0]                   pt_next;
    logic [PT_W-1:0]                   pt_inc;
    logic [PT_W-1:0]                   period;
    logic [ENABLE_W-1:0]               mask_reg;
    logic [ENABLE_W-1:0]               mask_next;
    logic [ENABLE_W-1:0]               lit_reg;
    logic [ENABLE_W-1:0]               lit_next;
    logic [NUM_GROUPS-1:0][CODE_W-1:0] grp_code_reg;
    logic [NUM_GROUPS-1:0][CODE_W-1:0] grp_code_next;
    logic [NUM_GROUPS-1:0]             grp_dot_reg;
    logic [NUM_GROUPS-1:0]             grp_dot_next;

    // output register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    // ---------------------------------------------------------------- store
    always_comb
    begin
        store_next = store_reg;
        widx_next  = widx_reg;
        if (cmd.do_char)
        begin
            if (char_reg == CHAR_CLEAR || widx_reg > PTR_W'(2 * NUM_TUBES))
            begin
                // last entry keeps its byte
                for (int i = 0; i < 2 * NUM_TUBES; i++)
                begin
                    store_next[i] = CHAR_SPACE;
                end
                widx_next = '0;
            end
            else
            begin
                store_next[widx_reg[IDX_W-1:0]] = char_reg;
                widx_next = widx_reg + 1'b1;
            end
        end
    end

    // ----------------------------------------------------------- store walk
    always_comb
    begin
        rd_byte = '0;
        if (pos_reg < PTR_W'(STORE_LEN))
        begin
            rd_byte = store_reg[pos_reg[IDX_W-1:0]];
        end
        // a dot byte read right after a dot is a plain (blank) character
        emit    = dotp_reg || (rd_byte != CHAR_DOT);
        rd_code = char_code(rd_byte);
        if (tube_reg < TUBE_W'(4))
        begin
            grp_sel = 2'd0;
        end
        else if (tube_reg < TUBE_W'(8))
        begin
            grp_sel = 2'd1;
        end
        else
        begin
            grp_sel = 2'd2;
        end
    end

    always_comb
    begin
        pos_next      = pos_reg;
        tube_next     = tube_reg;
        dotp_next     = dotp_reg;
        mask_next     = mask_reg;
        grp_code_next = grp_code_reg;
        grp_dot_next  = grp_dot_reg;
        if (cmd.parse_init)
        begin
            pos_next  = '0;
            tube_next = '0;
            dotp_next = 1'b0;
            for (int i = 0; i < ENABLE_W; i++)
            begin
                mask_next[i] = (i < NUM_TUBES) && (2'(i) == phase_reg);
            end
        end
        else if (cmd.parse_step)
        begin
            pos_next = pos_reg + 1'b1;
            if (emit)
            begin
                tube_next = tube_reg + 1'b1;
                dotp_next = 1'b0;
                if (tube_reg[1:0] == phase_reg)
                begin
                    grp_code_next[grp_sel] = rd_code;
                    grp_dot_next[grp_sel]  = dotp_reg;
                end
            end
            else
            begin
                dotp_next = 1'b1;
            end
        end
    end

    // ---------------------------------------------------------- scan timing
    always_comb
    begin
        pt_inc     = pt_reg + 1'b1;
        period     = {1'b0, on_reg} + {1'b0, off_reg};
        pt_next    = pt_reg;
        phase_next = phase_reg;
        lit_next   = lit_reg;
        if (cmd.finish && func_reg)
        begin
            lit_next = (pt_reg < {1'b0, on_reg}) ? mask_reg : '0;
            if (pt_inc >= period)
            begin
                pt_next    = '0;
                phase_next = phase_reg + 1'b1;
            end
            else
            begin
                pt_next = pt_inc;
            end
        end
    end

    // ------------------------------------------------------- output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {{PAD_W{1'b0}}, lit_next,
                              grp_dot_reg[2], grp_dot_reg[1], grp_dot_reg[0],
                              grp_code_reg[2], grp_code_reg[1], grp_code_reg[0]};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        sts.is_tick     = func_reg;
        sts.phase_start = (pt_reg == '0);
        sts.parse_last  = emit && (tube_reg == TUBE_W'(NUM_TUBES - 1));
        sts.out_free    = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // -------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg        <= ON_TICKS_RST;
            off_reg       <= OFF_TICKS_RST;
            store_reg     <= '0;
            widx_reg      <= '0;
            pos_reg       <= '0;
            tube_reg      <= '0;
            dotp_reg      <= 1'b0;
            phase_reg     <= '0;
            pt_reg        <= '0;
            mask_reg      <= '0;
            lit_reg       <= '0;
            grp_code_reg  <= {NUM_GROUPS{BLANK_CODE}};
            grp_dot_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == REG_ON_TICKS)
            begin
                on_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == REG_OFF_TICKS)
            begin
                off_reg <= cfg_data;
            end
            store_reg     <= store_next;
            widx_reg      <= widx_next;
            pos_reg       <= pos_next;
            tube_reg      <= tube_next;
            dotp_reg      <= dotp_next;
            phase_reg     <= phase_next;
            pt_reg        <= pt_next;
            mask_reg      <= mask_next;
            lit_reg       <= lit_next;
            grp_code_reg  <= grp_code_next;
            grp_dot_reg   <= grp_dot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg <= s_tuser;
            char_reg <= s_tdata;
        end
        out_data_reg <= out_data_next;
    end

endmodule

// ----- hw/rtl/nixie_display_multiplexer_unit.sv -----
// ----------------------------------------------------------------------------
// nixie_display_multiplexer_unit
// Multiplexed nixie tube driver: text store, four-phase scan, decoder codes.
// ----------------------------------------------------------------------------
// Each input transfer is a received character (tuser 0) or a one-microsecond
// tick (tuser 1) and yields exactly one output transfer with the group codes,
// dot bits and tube enables. The block handles one item at a time. A
// character, or a tick in the middle of a phase, goes through accept,
// execute and hand-off. A tick that opens a phase also walks the text store
// between execute and hand-off, one store byte per cycle. The output
// register lets the next item be accepted while a result waits; the
// hand-off cycle stalls only while the output register still holds an
// untaken result. Configuration writes are taken in any cycle and must only
// be issued while the block is idle.
// ----------------------------------------------------------------------------
module nixie_display_multiplexer_unit #(
    parameter int NUM_TUBES = ndm_pkg::NUM_TUBES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ndm_pkg::CHAR_W-1:0]      s_tdata,   // [7:0] rx_char
    input  logic                            s_tuser,   // [0] func
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [3:0] upper_code, [7:4] middle_code, [11:8] lower_code, [12] dot_upper,
    // [13] dot_middle, [14] dot_lower, [24:15] tube_enable, [31:25] zero
    output logic [ndm_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ndm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ndm_pkg::TICK_W-1:0]      cfg_data
);
    import ndm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    ndm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ndm_datapath #(
        .NUM_TUBES (NUM_TUBES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ----- hw/rtl/ndm_checker.sv -----
// ----------------------------------------------------------------------------
// ndm_checker
// Port-level checks of the nixie multiplexer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ndm_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ndm_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import ndm_pkg::*;

    localparam int EN_LSB = NUM_GROUPS * CODE_W + NUM_GROUPS;

    // stalled result holds
    `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "out stall")

    // one item in flight: no accept right after an accept
    `ASSERT_CLK(a_one_item, s_tvalid && s_tready |=> !s_tready, "back to back accept")

    // padding above the fields stays zero
    `ASSERT_NEVER(a_pad_zero, m_tvalid && (m_tdata[OUT_DATA_W-1:OUT_FIELD_W] != '0), "pad")

    // a phase lights at most one tube per group; checked here for the upper group
    `ASSERT_CLK(a_scan_upper, m_tvalid |-> $onehot0(m_tdata[EN_LSB +: 4]), "upper group")

    `ASSERT_CLK(a_scan_count, m_tvalid |-> $countones(m_tdata[EN_LSB +: ENABLE_W]) <= 3, "tubes")

endmodule

bind nixie_display_multiplexer_unit ndm_checker u_ndm_checker (.*);
